// ===== rtl/pvm_pkg.sv =====
// Package for the PCM voice mixer: command codes, field widths, defaults and
// the control structs between the controller and the datapath.
// Depends on nothing.
`default_nettype none

package pvm_pkg;

	localparam int VOICES_DEFAULT = 8;
	localparam int SAMPLE_ADDR_BITS_DEFAULT = 16;

	localparam int CMD_W = 2;
	localparam int VOICE_W = 3;
	localparam int ADDR_W = 16;
	localparam int LEN_W = 17;
	localparam int BYTE_W = 8;
	localparam int MIX_W = 16;
	localparam int STEP_W = 18;
	localparam int PEAK = 32767;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_START = 2'd2,
		CMD_STOP  = 2'd3
	} cmd_code_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic issue;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic last_voice;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/pvm_if.sv =====
// Request and result channel interfaces of the PCM voice mixer.
// Depends on pvm_pkg for the field widths.
`default_nettype none

interface pvm_req_if
	import pvm_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [VOICE_W-1:0]   voice;
	logic [ADDR_W-1:0]    start_address;
	logic [LEN_W-1:0]     clip_length;
	logic                 loop_enable;
	logic [ADDR_W-1:0]    write_address;
	logic [BYTE_W-1:0]    write_byte;

	modport source(output valid, command, voice, start_address, clip_length, loop_enable,
		write_address, write_byte, input ready);
	modport sink(input valid, command, voice, start_address, clip_length, loop_enable,
		write_address, write_byte, output ready);
endinterface

interface pvm_res_if
	import pvm_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [MIX_W-1:0]  mixed_sample;
	logic [VOICE_W-1:0]       voice_number;
	logic                     status;
	logic                     clipped;

	modport source(output valid, mixed_sample, voice_number, status, clipped, input ready);
	modport sink(input valid, mixed_sample, voice_number, status, clipped, output ready);
endinterface

`default_nettype wire

// ===== rtl/pcm_voice_mixer.sv =====
// Top level of the PCM voice mixer: a tick request yields its mix by reading
// its voices through the single sample memory read port that serves one voice
// per cycle, and the next request is taken once the result has been loaded.
// Reset clears all voices; the sample memory holds unknown bytes until written.
`default_nettype none

module pcm_voice_mixer
	import pvm_pkg::*;
#(
	parameter int VOICES = VOICES_DEFAULT,
	parameter int SAMPLE_ADDR_BITS = SAMPLE_ADDR_BITS_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	pvm_req_if.sink  req,
	pvm_res_if.source res
);

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	pvm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_command (req.command),
		.req_ready   (req.ready),
		.res_valid   (res.valid),
		.res_ready   (res.ready),
		.dp_cmd      (dp_cmd),
		.dp_status   (dp_status)
	);

	pvm_dp #(
		.VOICES           (VOICES),
		.SAMPLE_ADDR_BITS (SAMPLE_ADDR_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.dp_cmd            (dp_cmd),
		.dp_status         (dp_status),
		.req_command       (req.command),
		.req_voice         (req.voice),
		.req_start_address (req.start_address),
		.req_clip_length   (req.clip_length),
		.req_loop_enable   (req.loop_enable),
		.req_write_address (req.write_address),
		.req_write_byte    (req.write_byte),
		.res_mixed_sample  (res.mixed_sample),
		.res_voice_number  (res.voice_number),
		.res_status        (res.status),
		.res_clipped       (res.clipped)
	);

endmodule

`default_nettype wire

// ===== rtl/pvm_ctrl.sv =====
// Controller state machine of the PCM voice mixer: sequences each request
// and owns the result valid flag. Depends on pvm_pkg.
`default_nettype none

module pvm_ctrl
	import pvm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	input  wire logic [CMD_W-1:0] req_command,
	output logic                  req_ready,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output dp_cmd_t               dp_cmd,
	input  wire dp_status_t       dp_status
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_TICK,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   load_ok;

	assign req_ready = (state_q == ST_IDLE);
	assign accept = req_valid && req_ready;
	assign load_ok = (state_q == ST_DONE) && (!out_valid_q || res_ready);
	assign res_valid = out_valid_q;

	always_comb begin
		dp_cmd.capture = accept;
		dp_cmd.exec = (state_q == ST_EXEC);
		dp_cmd.issue = (state_q == ST_TICK);
		dp_cmd.load = load_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_ok) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (req_command == CMD_TICK) ? ST_TICK : ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
				end
				ST_TICK: begin
					if (dp_status.last_voice) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pvm_dp.sv =====
// Datapath of the PCM voice mixer: sample memory, voice table, mix accumulator
// and result register. Driven by pvm_ctrl; depends on pvm_pkg.
`default_nettype none

module pvm_dp
	import pvm_pkg::*;
#(
	parameter int VOICES = VOICES_DEFAULT,
	parameter int SAMPLE_ADDR_BITS = SAMPLE_ADDR_BITS_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dp_cmd_t               dp_cmd,
	output dp_status_t                 dp_status,
	input  wire logic [CMD_W-1:0]      req_command,
	input  wire logic [VOICE_W-1:0]    req_voice,
	input  wire logic [ADDR_W-1:0]     req_start_address,
	input  wire logic [LEN_W-1:0]      req_clip_length,
	input  wire logic                  req_loop_enable,
	input  wire logic [ADDR_W-1:0]     req_write_address,
	input  wire logic [BYTE_W-1:0]     req_write_byte,
	output logic signed [MIX_W-1:0]    res_mixed_sample,
	output logic [VOICE_W-1:0]         res_voice_number,
	output logic                       res_status,
	output logic                       res_clipped
);

	localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int AW = SAMPLE_ADDR_BITS;
	localparam int DEPTH = 1 << SAMPLE_ADDR_BITS;
	localparam int ACC_W = $clog2(VOICES) + 18;
	localparam logic signed [ACC_W-1:0] AccMax = ACC_W'(PEAK);
	localparam logic signed [ACC_W-1:0] AccMin = -AccMax;

	cmd_code_t            cmd_q;
	logic [VOICE_W-1:0]   voice_q;
	logic [ADDR_W-1:0]    start_q;
	logic [LEN_W-1:0]     len_q;
	logic                 loop_q;
	logic [ADDR_W-1:0]    waddr_q;
	logic [BYTE_W-1:0]    wbyte_q;

	logic [BYTE_W-1:0]    mem [DEPTH];
	logic [BYTE_W-1:0]    rd_q;
	logic [AW-1:0]        rd_addr;

	logic [VOICES-1:0]    act_q;
	logic                 looping_q [VOICES];
	logic [STEP_W-1:0]    step_q [VOICES];
	logic [AW-1:0]        base_q [VOICES];
	logic [LEN_W-1:0]     length_q [VOICES];

	logic [VIDX_W-1:0]    vcnt_q;
	logic                 issue_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic [VOICE_W-1:0]   num_q;
	logic                 stat_q;

	logic [LEN_W-1:0]     pos;
	logic                 plays;
	logic [STEP_W-1:0]    step_next;
	logic                 ends;
	logic [VIDX_W-1:0]    free_idx;
	logic                 free_found;
	logic [VIDX_W-1:0]    stop_idx;
	logic                 stop_ok;
	logic signed [16:0]   widened;

	assign pos = step_q[vcnt_q][STEP_W-1:1];
	assign plays = act_q[vcnt_q] && (pos < length_q[vcnt_q]);
	assign step_next = step_q[vcnt_q] + STEP_W'(1);
	assign ends = (step_next[STEP_W-1:1] >= length_q[vcnt_q]);
	assign rd_addr = base_q[vcnt_q] + AW'(pos);
	assign dp_status.last_voice = (vcnt_q == VIDX_W'(VOICES - 1));
	assign stop_idx = VIDX_W'(voice_q);
	assign stop_ok = (int'(voice_q) < VOICES);
	assign widened = $signed({1'b0, rd_q, rd_q}) - 17'sd32767;

	always_comb begin
		free_idx = '0;
		free_found = 1'b0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (!act_q[i]) begin
				free_idx = VIDX_W'(i);
				free_found = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			cmd_q <= cmd_code_t'(req_command);
			voice_q <= req_voice;
			start_q <= req_start_address;
			len_q <= req_clip_length;
			loop_q <= req_loop_enable;
			waddr_q <= req_write_address;
			wbyte_q <= req_write_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.exec && cmd_q == CMD_WRITE) begin
			mem[AW'(waddr_q)] <= wbyte_q;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
		end else if (dp_cmd.issue && plays && ends && !looping_q[vcnt_q]) begin
			act_q[vcnt_q] <= 1'b0;
		end else if (dp_cmd.exec && cmd_q == CMD_START && free_found) begin
			act_q[free_idx] <= 1'b1;
		end else if (dp_cmd.exec && cmd_q == CMD_STOP && stop_ok) begin
			act_q[stop_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.issue && plays) begin
			step_q[vcnt_q] <= (ends && looping_q[vcnt_q]) ? '0 : step_next;
		end else if (dp_cmd.exec && cmd_q == CMD_START && free_found) begin
			step_q[free_idx] <= '0;
			base_q[free_idx] <= AW'(start_q);
			length_q[free_idx] <= len_q;
			looping_q[free_idx] <= loop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q <= '0;
			issue_s1 <= 1'b0;
		end else begin
			issue_s1 <= dp_cmd.issue && plays;
			if (dp_cmd.capture) begin
				vcnt_q <= '0;
			end else if (dp_cmd.issue) begin
				vcnt_q <= vcnt_q + VIDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			acc_q <= '0;
			num_q <= '0;
			stat_q <= 1'b0;
		end else begin
			if (issue_s1) begin
				acc_q <= acc_q + ACC_W'(widened);
			end
			if (dp_cmd.exec && cmd_q == CMD_START) begin
				num_q <= free_found ? VOICE_W'(free_idx) : '0;
				stat_q <= !free_found;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			res_voice_number <= num_q;
			res_status <= stat_q;
			if (cmd_q != CMD_TICK) begin
				res_mixed_sample <= '0;
				res_clipped <= 1'b0;
			end else if (acc_q > AccMax) begin
				res_mixed_sample <= MIX_W'(AccMax);
				res_clipped <= 1'b1;
			end else if (acc_q < AccMin) begin
				res_mixed_sample <= MIX_W'(AccMin);
				res_clipped <= 1'b1;
			end else begin
				res_mixed_sample <= MIX_W'(acc_q);
				res_clipped <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== tb/pcm_voice_mixer_scoreboard.sv =====
`timescale 1ns / 1ps
// Scoreboard for the PCM voice mixer: watches the request and result channels,
// predicts each result from its own copy of the voices and the sample memory.
// Depends on pvm_pkg and the channel interfaces in pvm_if.
module pcm_voice_mixer_scoreboard
	import pvm_pkg::*;
#(
	parameter int VOICES = VOICES_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	pvm_req_if req,
	pvm_res_if res,
	output int mismatches,
	output int outstanding
);

	typedef struct packed {
		logic signed [MIX_W-1:0] mixed_sample;
		logic [VOICE_W-1:0] voice_number;
		logic status;
		logic clipped;
	} mix_result_t;

	logic [BYTE_W-1:0] sample_store [2**ADDR_W];
	logic voice_active [VOICES];
	logic voice_looping [VOICES];
	logic [STEP_W-1:0] voice_halfstep [VOICES];
	logic [ADDR_W-1:0] voice_base [VOICES];
	logic [LEN_W-1:0] voice_length [VOICES];
	mix_result_t expected_mix [$];

	function automatic mix_result_t predict_mix(input cmd_code_t command,
		input logic [VOICE_W-1:0] voice, input logic [ADDR_W-1:0] start_address,
		input logic [LEN_W-1:0] clip_length, input logic loop_enable,
		input logic [ADDR_W-1:0] write_address, input logic [BYTE_W-1:0] write_byte);
		mix_result_t r;
		int sum;
		int v;
		int slot;
		logic [LEN_W-1:0] pos;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] d;
		r = '0;
		sum = 0;
		case (command)
		CMD_TICK: begin
			for (v = 0; v < VOICES; v++) begin
				pos = voice_halfstep[v][STEP_W-1:1];
				if (voice_active[v] && pos < voice_length[v]) begin
					addr = voice_base[v] + ADDR_W'(pos);
					d = sample_store[addr];
					sum += int'({d, d}) - PEAK;
					voice_halfstep[v] = voice_halfstep[v] + 1'b1;
					if (voice_halfstep[v][STEP_W-1:1] >= voice_length[v]) begin
						if (voice_looping[v]) begin
							voice_halfstep[v] = '0;
						end else begin
							voice_active[v] = 1'b0;
						end
					end
				end
			end
			if (sum > PEAK) begin
				sum = PEAK;
				r.clipped = 1'b1;
			end else if (sum < -PEAK) begin
				sum = -PEAK;
				r.clipped = 1'b1;
			end
			r.mixed_sample = MIX_W'(sum);
		end
		CMD_WRITE: begin
			sample_store[write_address] = write_byte;
		end
		CMD_START: begin
			slot = VOICES;
			for (v = VOICES - 1; v >= 0; v--) begin
				if (!voice_active[v]) begin
					slot = v;
				end
			end
			if (slot < VOICES) begin
				voice_base[slot] = start_address;
				voice_length[slot] = clip_length;
				voice_looping[slot] = loop_enable;
				voice_halfstep[slot] = '0;
				voice_active[slot] = 1'b1;
				r.voice_number = VOICE_W'(slot);
			end else begin
				r.status = 1'b1;
			end
		end
		CMD_STOP: begin
			if (voice < VOICES) begin
				voice_active[voice] = 1'b0;
			end
		end
		endcase
		return r;
	endfunction

	// The result side is handled before the request side so that a result can
	// never be matched against an expectation pushed at the same clock edge.
	always @(posedge clk or negedge arst_n) begin
		mix_result_t got;
		mix_result_t want;
		if (!arst_n) begin
			for (int v = 0; v < VOICES; v++) begin
				voice_active[v] = 1'b0;
				voice_looping[v] = 1'b0;
				voice_halfstep[v] = '0;
				voice_base[v] = '0;
				voice_length[v] = '0;
			end
			expected_mix.delete();
			mismatches = 0;
		end else begin
			if (res.valid && res.ready) begin
				got.mixed_sample = res.mixed_sample;
				got.voice_number = res.voice_number;
				got.status = res.status;
				got.clipped = res.clipped;
				if (expected_mix.size() == 0) begin
					$error("result with no request outstanding: mixed_sample %0d",
						$signed(got.mixed_sample));
					mismatches++;
				end else begin
					want = expected_mix.pop_front();
					if (got.mixed_sample !== want.mixed_sample) begin
						$error("mixed_sample: expected %0d, got %0d",
							$signed(want.mixed_sample), $signed(got.mixed_sample));
						mismatches++;
					end
					if (got.voice_number !== want.voice_number) begin
						$error("voice_number: expected %0d, got %0d",
							want.voice_number, got.voice_number);
						mismatches++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						mismatches++;
					end
					if (got.clipped !== want.clipped) begin
						$error("clipped: expected %0d, got %0d", want.clipped, got.clipped);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready) begin
				expected_mix.push_back(predict_mix(cmd_code_t'(req.command), req.voice,
					req.start_address, req.clip_length, req.loop_enable,
					req.write_address, req.write_byte));
			end
		end
		outstanding = expected_mix.size();
	end

endmodule

// ===== tb/pcm_voice_mixer_test.sv =====
`timescale 1ns / 1ps
// Top of the PCM voice mixer testbench: clock, reset, request stimulus and
// result back-pressure; instantiates the mixer and its scoreboard.
// Depends on pvm_pkg, pvm_if, pcm_voice_mixer and pcm_voice_mixer_scoreboard.
module pcm_voice_mixer_test;
	import pvm_pkg::*;

	localparam int WINDOW_BYTES = 64;
	localparam logic [ADDR_W-1:0] WINDOW_BASE = 16'hFFF0;
	localparam int HOLD_CYCLES = 64;
	localparam int NO_LIMIT = 1 << 30;
	localparam int PHASE_ITEMS = 240;
	localparam int DRAIN_CYCLES = 2 * (VOICES_DEFAULT + 3);

	typedef struct packed {
		cmd_code_t command;
		logic [VOICE_W-1:0] voice;
		logic [ADDR_W-1:0] start_address;
		logic [LEN_W-1:0] clip_length;
		logic loop_enable;
		logic [ADDR_W-1:0] write_address;
		logic [BYTE_W-1:0] write_byte;
	} mixer_request_t;

	logic clk = 1'b0;
	logic arst_n;
	logic hold_output = 1'b0;
	int sender_idle = 25;
	int receiver_idle = 76;
	int items_sent = 0;
	int tick_room = NO_LIMIT;
	int mismatches;
	int outstanding;

	pvm_req_if req_bus ();
	pvm_res_if res_bus ();

	pcm_voice_mixer uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.res(res_bus)
	);

	pcm_voice_mixer_scoreboard score (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.res(res_bus),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		res_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_output) begin
				res_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_output = 1'b0;
			end else begin
				res_bus.ready <= ($urandom_range(99) >= receiver_idle);
			end
		end
	end

	function automatic mixer_request_t random_request(input cmd_code_t command);
		logic [63:0] raw_bits;
		logic [$bits(mixer_request_t)-1:0] noise_bits;
		mixer_request_t r;
		raw_bits = {$urandom, $urandom};
		noise_bits = raw_bits[$bits(mixer_request_t)-1:0];
		r = noise_bits;
		r.command = command;
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] window_address(input int offset);
		return WINDOW_BASE + ADDR_W'(offset);
	endfunction

	function automatic logic [BYTE_W-1:0] random_sample();
		case ($urandom_range(3))
		0: return 8'h00;
		1: return 8'hFF;
		default: return BYTE_W'($urandom);
		endcase
	endfunction

	task automatic send_request(input mixer_request_t r);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.command <= r.command;
		req_bus.voice <= r.voice;
		req_bus.start_address <= r.start_address;
		req_bus.clip_length <= r.clip_length;
		req_bus.loop_enable <= r.loop_enable;
		req_bus.write_address <= r.write_address;
		req_bus.write_byte <= r.write_byte;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic write_sample(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data);
		mixer_request_t r;
		r = random_request(CMD_WRITE);
		r.write_address = addr;
		r.write_byte = data;
		send_request(r);
	endtask

	task automatic start_clip(input logic [ADDR_W-1:0] base, input logic [LEN_W-1:0] len,
		input logic looping);
		mixer_request_t r;
		r = random_request(CMD_START);
		r.start_address = base;
		r.clip_length = len;
		r.loop_enable = looping;
		send_request(r);
	endtask

	task automatic stop_voice(input logic [VOICE_W-1:0] slot);
		mixer_request_t r;
		r = random_request(CMD_STOP);
		r.voice = slot;
		send_request(r);
	endtask

	task automatic stop_all();
		int v;
		for (v = 0; v < VOICES_DEFAULT; v++) begin
			stop_voice(VOICE_W'(v));
		end
		tick_room = NO_LIMIT;
	endtask

	// A long clip may only run while its reads stay inside the written window,
	// so every voice is stopped once the tick budget has run out, before the next tick.
	task automatic tick_frame();
		if (tick_room == 0) begin
			stop_all();
		end
		send_request(random_request(CMD_TICK));
		if (tick_room != NO_LIMIT) begin
			tick_room--;
		end
	endtask

	task automatic random_sequence();
		int choice;
		int offset;
		logic [LEN_W-1:0] len;
		choice = $urandom_range(99);
		if (choice < 40) begin
			offset = $urandom_range(WINDOW_BYTES - 1);
			len = LEN_W'($urandom_range(16));
			if ($urandom_range(7) == 0 || len > WINDOW_BYTES - offset) begin
				len = LEN_W'(WINDOW_BYTES - offset);
			end
			start_clip(window_address(offset), len, 1'($urandom_range(1)));
			repeat ($urandom_range(12, 1)) tick_frame();
		end else if (choice < 50) begin
			offset = $urandom_range(8);
			if ($urandom_range(3) == 0) begin
				len = LEN_W'(65536);
			end else begin
				len = LEN_W'($urandom_range(65536, WINDOW_BYTES - offset + 1));
			end
			start_clip(window_address(offset), len, 1'($urandom_range(1)));
			if (2 * (WINDOW_BYTES - offset) < tick_room) begin
				tick_room = 2 * (WINDOW_BYTES - offset);
			end
			repeat ($urandom_range(20, 1)) tick_frame();
		end else if (choice < 68) begin
			repeat ($urandom_range(8, 1)) tick_frame();
		end else if (choice < 77) begin
			repeat ($urandom_range(3, 1)) begin
				if ($urandom_range(1) == 0) begin
					write_sample(window_address($urandom_range(WINDOW_BYTES - 1)),
						random_sample());
				end else begin
					write_sample(ADDR_W'($urandom), random_sample());
				end
			end
		end else if (choice < 89) begin
			stop_voice(VOICE_W'($urandom));
		end else if (choice < 95) begin
			stop_all();
		end else begin
			repeat ($urandom_range(9, 1)) begin
				start_clip(ADDR_W'($urandom), '0, 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		int i;
		int phase;
		int phase_end;
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.command = CMD_TICK;
		req_bus.voice = '0;
		req_bus.start_address = '0;
		req_bus.clip_length = '0;
		req_bus.loop_enable = 1'b0;
		req_bus.write_address = '0;
		req_bus.write_byte = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tick_frame();
		write_sample(16'hFFFF, 8'hFF);
		write_sample(16'h0000, 8'h00);
		write_sample(16'h0001, 8'h7F);
		write_sample(16'h0002, 8'h80);
		stop_voice(3'd5);
		start_clip(16'hFFFF, 17'd1, 1'b0);
		tick_frame();
		tick_frame();
		start_clip(16'h0000, 17'd1, 1'b1);
		start_clip(16'h0000, 17'd1, 1'b1);
		tick_frame();
		start_clip(16'hFFFF, 17'd4, 1'b1);
		tick_frame();
		start_clip(16'h0001, 17'd0, 1'b0);
		start_clip(16'h0000, 17'h10000, 1'b0);
		tick_room = 4;
		repeat (3) start_clip(16'h8000, 17'd0, 1'b1);
		start_clip(16'h0000, 17'd1, 1'b0);
		repeat (3) tick_frame();
		stop_voice(3'd4);
		stop_voice(3'd7);

		for (i = 0; i < WINDOW_BYTES; i++) begin
			write_sample(window_address(i), random_sample());
		end

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
			0: begin
				sender_idle = 25;
				receiver_idle = 76;
			end
			1: begin
				sender_idle = 76;
				receiver_idle = 25;
			end
			default: begin
				sender_idle = 0;
				receiver_idle = 0;
			end
			endcase
			hold_output = 1'b1;
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				random_sequence();
			end
		end

		@(negedge clk);
		req_bus.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
